// File: src/lun_pkg.sv
// Package for the Latin-1 Unicode normaliser: payload and queue types, form bit
// positions, the composition table and its lookup functions.
// Depends on nothing; every other file of the block uses it.
package lun_pkg;

    // Bit positions inside the two-bit normalisation form register.
    localparam int FORM_DECOMP_BIT = 0;
    localparam int FORM_COMPAT_BIT = 1;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    localparam int TABLE_SIZE = 53;

    // Special code units of the compatibility forms.
    localparam logic [15:0] NO_BREAK_SPACE = 16'h00A0;
    localparam logic [15:0] SPACE          = 16'h0020;
    localparam logic [15:0] LIGATURE_FI    = 16'hFB01;
    localparam logic [15:0] LETTER_F       = 16'h0066;
    localparam logic [15:0] LETTER_I       = 16'h0069;

    // Each entry holds composed letter, base letter and combining mark.
    localparam logic [47:0] LATIN_TABLE [TABLE_SIZE] = '{
        {16'h00C0, 16'h0041, 16'h0300}, {16'h00C1, 16'h0041, 16'h0301},
        {16'h00C2, 16'h0041, 16'h0302}, {16'h00C3, 16'h0041, 16'h0303},
        {16'h00C4, 16'h0041, 16'h0308}, {16'h00C5, 16'h0041, 16'h030A},
        {16'h00C7, 16'h0043, 16'h0327}, {16'h00C8, 16'h0045, 16'h0300},
        {16'h00C9, 16'h0045, 16'h0301}, {16'h00CA, 16'h0045, 16'h0302},
        {16'h00CB, 16'h0045, 16'h0308}, {16'h00CC, 16'h0049, 16'h0300},
        {16'h00CD, 16'h0049, 16'h0301}, {16'h00CE, 16'h0049, 16'h0302},
        {16'h00CF, 16'h0049, 16'h0308}, {16'h00D1, 16'h004E, 16'h0303},
        {16'h00D2, 16'h004F, 16'h0300}, {16'h00D3, 16'h004F, 16'h0301},
        {16'h00D4, 16'h004F, 16'h0302}, {16'h00D5, 16'h004F, 16'h0303},
        {16'h00D6, 16'h004F, 16'h0308}, {16'h00D9, 16'h0055, 16'h0300},
        {16'h00DA, 16'h0055, 16'h0301}, {16'h00DB, 16'h0055, 16'h0302},
        {16'h00DC, 16'h0055, 16'h0308}, {16'h00DD, 16'h0059, 16'h0301},
        {16'h00E0, 16'h0061, 16'h0300}, {16'h00E1, 16'h0061, 16'h0301},
        {16'h00E2, 16'h0061, 16'h0302}, {16'h00E3, 16'h0061, 16'h0303},
        {16'h00E4, 16'h0061, 16'h0308}, {16'h00E5, 16'h0061, 16'h030A},
        {16'h00E7, 16'h0063, 16'h0327}, {16'h00E8, 16'h0065, 16'h0300},
        {16'h00E9, 16'h0065, 16'h0301}, {16'h00EA, 16'h0065, 16'h0302},
        {16'h00EB, 16'h0065, 16'h0308}, {16'h00EC, 16'h0069, 16'h0300},
        {16'h00ED, 16'h0069, 16'h0301}, {16'h00EE, 16'h0069, 16'h0302},
        {16'h00EF, 16'h0069, 16'h0308}, {16'h00F1, 16'h006E, 16'h0303},
        {16'h00F2, 16'h006F, 16'h0300}, {16'h00F3, 16'h006F, 16'h0301},
        {16'h00F4, 16'h006F, 16'h0302}, {16'h00F5, 16'h006F, 16'h0303},
        {16'h00F6, 16'h006F, 16'h0308}, {16'h00F9, 16'h0075, 16'h0300},
        {16'h00FA, 16'h0075, 16'h0301}, {16'h00FB, 16'h0075, 16'h0302},
        {16'h00FC, 16'h0075, 16'h0308}, {16'h00FD, 16'h0079, 16'h0301},
        {16'h00FF, 16'h0079, 16'h0308}
    };

    // Input and result payloads.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } lun_in_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        out_last;
    } lun_out_t;

    // One decomposed request as it waits in the queue.
    typedef struct packed {
        logic [15:0] d0;
        logic [15:0] d1;
        logic        two;
        logic        eos;
    } lun_entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic not_empty;
    } lun_q_stat_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] unit;
    } lun_comp_t;

    // Decompose one code unit; the end-of-string flag is filled in by the caller.
    function automatic lun_entry_t lun_decompose(input logic [15:0] u, input logic compat);
        lun_entry_t e;
        logic       hit;
        e   = '0;
        hit = 1'b0;
        e.d0 = u;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (LATIN_TABLE[i][47:32] == u) begin
                hit   = 1'b1;
                e.d0  = LATIN_TABLE[i][31:16];
                e.d1  = LATIN_TABLE[i][15:0];
                e.two = 1'b1;
            end
        end
        if (!hit && compat && u == NO_BREAK_SPACE) begin
            e.d0 = SPACE;
        end
        if (!hit && compat && u == LIGATURE_FI) begin
            e.d0  = LETTER_F;
            e.d1  = LETTER_I;
            e.two = 1'b1;
        end
        return e;
    endfunction

    // Look up the composed letter of a base letter and a combining mark.
    function automatic lun_comp_t lun_compose(input logic [15:0] a, input logic [15:0] b);
        lun_comp_t c;
        c = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (LATIN_TABLE[i][31:16] == a && LATIN_TABLE[i][15:0] == b) begin
                c.hit  = 1'b1;
                c.unit = LATIN_TABLE[i][47:32];
            end
        end
        return c;
    endfunction

endpackage

// File: src/lun_front.sv
// Front of the normaliser: takes input requests and decomposes them.
// Depends on lun_pkg; feeds lun_queue.
module lun_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lun_pkg::lun_in_t     s_payload,
    input  logic                 compat,
    input  lun_pkg::lun_q_stat_t q_stat,
    output logic                 q_push,
    output lun_pkg::lun_entry_t  q_data
);

    lun_pkg::lun_entry_t dec;

    // A request is taken whenever the queue has room.
    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;

    // Table decomposition plus the compatibility mappings.
    always_comb begin
        dec     = lun_pkg::lun_decompose(s_payload.code_unit, compat);
        dec.eos = s_payload.end_of_string;
        q_data  = dec;
    end

endmodule

// File: src/lun_queue.sv
// Short queue of decomposed requests between front and back.
// Depends on lun_pkg for the entry and status types.
module lun_queue #(
    parameter int DEPTH = lun_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lun_pkg::lun_entry_t  push_data,
    input  logic                 pop,
    output lun_pkg::lun_entry_t  head,
    output lun_pkg::lun_q_stat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lun_pkg::lun_entry_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign head           = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && stat.full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> stat.not_empty)
        else $error("queue read while empty");
`endif

endmodule

// File: src/lun_back.sv
// Back of the normaliser: composes against the pending unit and sends out
// one result unit per cycle through the output register, while the output port is not stalled.
// Depends on lun_pkg; takes requests from lun_queue.
module lun_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 decomp_only,
    input  lun_pkg::lun_entry_t  head,
    input  lun_pkg::lun_q_stat_t q_stat,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lun_pkg::lun_out_t    m_payload
);

    logic              pend_valid_reg, pend_valid_next;
    logic [15:0]       pend_unit_reg, pend_unit_next;
    logic [1:0]        idx_reg, idx_next;
    logic              m_valid_reg, m_valid_next;
    lun_pkg::lun_out_t m_payload_reg, m_payload_next;

    logic [15:0]       res [3];
    logic [1:0]        n;
    logic              pv;
    logic [15:0]       pu;
    lun_pkg::lun_comp_t c0, c1;
    logic              slot_free, step, last;

    // Both candidate compositions are looked up in parallel.
    assign c0 = lun_pkg::lun_compose(pend_unit_reg, head.d0);
    assign c1 = lun_pkg::lun_compose(head.d0, head.d1);

    // Result list of the request at the head of the queue.
    always_comb begin
        res[0] = '0;
        res[1] = '0;
        res[2] = '0;
        n  = '0;
        pv = pend_valid_reg;
        pu = pend_unit_reg;
        if (decomp_only) begin
            if (pv) begin
                res[n] = pu;
                n = n + 2'd1;
            end
            res[n] = head.d0;
            n = n + 2'd1;
            if (head.two) begin
                res[n] = head.d1;
                n = n + 2'd1;
            end
            pv = 1'b0;
            pu = '0;
        end else begin
            // First decomposed unit against the pending unit.
            if (pv && c0.hit) begin
                res[n] = c0.unit;
                n = n + 2'd1;
                pv = 1'b0;
                pu = '0;
            end else begin
                if (pv) begin
                    res[n] = pu;
                    n = n + 2'd1;
                end
                pv = 1'b1;
                pu = head.d0;
            end
            // Second unit: the pending unit can only be the first one here.
            if (head.two) begin
                if (pv && c1.hit) begin
                    res[n] = c1.unit;
                    n = n + 2'd1;
                    pv = 1'b0;
                    pu = '0;
                end else begin
                    if (pv) begin
                        res[n] = pu;
                        n = n + 2'd1;
                    end
                    pv = 1'b1;
                    pu = head.d1;
                end
            end
            // End of string flushes whatever is still pending.
            if (head.eos && pv) begin
                res[n] = pu;
                n = n + 2'd1;
                pv = 1'b0;
                pu = '0;
            end
        end
    end

    // Sequencing of the head request, one result per free output slot.
    always_comb begin
        slot_free       = !m_valid_reg || m_ready;
        step            = q_stat.not_empty && slot_free;
        last            = (n == '0) || (idx_reg == n - 2'd1);
        pop             = step && last;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_unit_next  = pend_unit_reg;
        m_valid_next    = m_valid_reg;
        m_payload_next  = m_payload_reg;
        if (step) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
        if (pop) begin
            pend_valid_next = pv;
            pend_unit_next  = pu;
        end
        if (slot_free) begin
            m_valid_next            = step && (n != '0);
            m_payload_next.out_unit = res[idx_reg];
            m_payload_next.out_last = head.eos && last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_unit_reg  <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            pend_unit_reg  <= pend_unit_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTH
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd3)
        else $error("result index out of range");
    a_decomp_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && (decomp_only || head.eos)) |=> !pend_valid_reg)
        else $error("pending unit kept after flush");
`endif

endmodule

// File: src/latin1_unicode_normalizer_unit.sv
// Latin-1 Unicode normaliser (NFC, NFD, NFKC, NFKD) on a UTF-16 code-unit stream.
// An accepted request is held in the queue; its first result then goes to the output register.
// Throughput: one result unit per cycle while the output port accepts; a request stays
// at the back until every unit it yields is sent, or is popped without output if it only becomes pending.
// Reset: form returns to NFC, the pending unit and the request queue are emptied.
// Depends on lun_pkg, lun_front, lun_queue and lun_back.
module latin1_unicode_normalizer_unit #(
    parameter int QUEUE_DEPTH = lun_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  lun_pkg::lun_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output lun_pkg::lun_out_t m_payload
);

    logic [1:0]           form_reg, form_next;
    lun_pkg::lun_q_stat_t q_stat;
    lun_pkg::lun_entry_t  q_data, q_head;
    logic                 q_push, q_pop;

    // Normalisation form register.
    always_comb begin
        form_next = cfg_wr_en ? cfg_wr_data : form_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            form_reg <= '0;
        end else begin
            form_reg <= form_next;
        end
    end

    lun_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .compat    (form_reg[lun_pkg::FORM_COMPAT_BIT]),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    lun_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    lun_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .decomp_only (form_reg[lun_pkg::FORM_DECOMP_BIT]),
        .head        (q_head),
        .q_stat      (q_stat),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

endmodule
